// ----- rtl/core/pwa_pkg.sv -----
package pwa_pkg;

  // Default configuration limits
  localparam int DEF_MAX_LENGTH_LOG2 = 10;
  localparam int DEF_MAX_TAPS        = 32;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int CIDX_W     = 5;
  localparam int COEF_W     = 18;
  localparam int SMP_W      = 24;
  localparam int RIDX_W     = 10;
  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int LEN_REG_W  = 4;
  localparam int LEV_REG_W  = 4;
  localparam int TAPS_REG_W = 6;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS        = 2'd2;

  // Register reset values
  localparam logic [LEN_REG_W-1:0]  RST_LENGTH_LOG2 = 4'd10;
  localparam logic [LEV_REG_W-1:0]  RST_LEVELS      = 4'd1;
  localparam logic [TAPS_REG_W-1:0] RST_TAPS        = 6'd4;

  // 1/sqrt2 in Q0.17 and the scaler's magnitude clamp
  localparam int MAG_W   = 48;
  localparam int K_W     = 17;
  localparam int SPROD_W = MAG_W + K_W;
  localparam logic [K_W-1:0] INV_SQRT2_Q17 = 17'd92682;

  typedef struct packed {
    logic issue;     // a tap/sample pair is being read this cycle
    logic neg;       // negate the highpass product of that pair
    logic clear;     // zero both accumulators
    logic scale_go;  // load the scaler product
    logic scale_hi;  // scaler takes the highpass accumulator
  } mac_ctl_t;

endpackage

// ----- rtl/core/pwa_mac.sv -----
module pwa_mac
  import pwa_pkg::*;
#(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] tap_lo,
  input  logic signed [COEF_W-1:0] tap_hi,
  input  logic signed [WORD_W-1:0] x,
  output logic                     busy,
  output logic signed [WORD_W-1:0] result
);

  localparam int PW    = COEF_W + WORD_W;
  localparam int ACC_W = PW + $clog2(MAX_TAPS) + 1;

  logic                     v1_r, v2_r, neg1_r;
  logic signed [PW-1:0]     p_lo_r, p_hi_r;
  logic signed [ACC_W-1:0]  acc_lo_r, acc_hi_r;
  logic [SPROD_W-1:0]       sc_prod_r;
  logic                     sc_neg_r;

  logic signed [PW-1:0]     prod_lo, prod_hi, prod_hi_raw;
  logic signed [ACC_W-1:0]  acc_sel;
  logic [ACC_W-1:0]         mag;
  logic [MAG_W-1:0]         mag_c;
  logic                     sel_neg;
  logic [SPROD_W-1:0]       rnd;
  logic [WORD_W:0]          rmag;
  logic [WORD_W:0]          rneg;

  always_comb begin
    prod_lo     = tap_lo * x;
    prod_hi_raw = tap_hi * x;
    prod_hi     = neg1_r ? -prod_hi_raw : prod_hi_raw;
  end

  // Magnitude, clamp to 2^47, multiply by 1/sqrt2
  always_comb begin
    acc_sel = ctl.scale_hi ? acc_hi_r : acc_lo_r;
    sel_neg = acc_sel[ACC_W-1];
    mag     = sel_neg ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
    if (mag > (ACC_W'(1) << (MAG_W - 1))) begin
      mag_c = MAG_W'(1) << (MAG_W - 1);
    end else begin
      mag_c = mag[MAG_W-1:0];
    end
  end

  // Round half away from zero, restore sign, saturate
  always_comb begin
    rnd  = sc_prod_r + (SPROD_W'(1) << (WORD_W - 1));
    rmag = rnd[SPROD_W-1 -: (WORD_W + 1)];
    rneg = (WORD_W + 1)'(0) - rmag;
    if (sc_neg_r) begin
      if (rmag > ((WORD_W + 1)'(1) << (WORD_W - 1))) begin
        result = {1'b1, {(WORD_W - 1){1'b0}}};
      end else begin
        result = rneg[WORD_W-1:0];
      end
    end else begin
      if (rmag > (WORD_W + 1)'({1'b0, {(WORD_W - 1){1'b1}}})) begin
        result = {1'b0, {(WORD_W - 1){1'b1}}};
      end else begin
        result = rmag[WORD_W-1:0];
      end
    end
  end

  assign busy = v1_r | v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    neg1_r <= ctl.neg;
    p_lo_r <= prod_lo;
    p_hi_r <= prod_hi;
    if (ctl.clear) begin
      acc_lo_r <= '0;
      acc_hi_r <= '0;
    end else if (v2_r) begin
      acc_lo_r <= acc_lo_r + ACC_W'(p_lo_r);
      acc_hi_r <= acc_hi_r + ACC_W'(p_hi_r);
    end
    if (ctl.scale_go) begin
      sc_prod_r <= SPROD_W'(mag_c) * SPROD_W'(INV_SQRT2_Q17);
      sc_neg_r  <= sel_neg;
    end
  end

endmodule

// ----- rtl/core/periodic_wavelet_analysis.sv -----
// Periodic multi-level wavelet analysis with circular borders. Load lowpass
// taps with func LOAD; the highpass taps are their mirror with alternating
// signs. Push samples with func PUSH; the push that completes a
// frame of 2^length_log2 samples starts the transform, and the block stalls
// its input until it finishes. Each output pair of a level runs on the one
// shared paired multiply-accumulate unit: the taps issue, the pipeline
// drains, and both halves are scaled and stored; every level but the last
// is followed by a copy sweep through the work memory. A READ returns one
// beat with the coefficient at read_index (standard layout, final lowpass
// first) and result_ready. Configuration writes are taken only while idle;
// a write to any of the three registers restarts the frame and drops the
// held result.
module periodic_wavelet_analysis
  import pwa_pkg::*;
#(
  parameter int MAX_LENGTH_LOG2 = DEF_MAX_LENGTH_LOG2,
  parameter int MAX_TAPS        = DEF_MAX_TAPS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [CIDX_W-1:0]        in_coef_index,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic signed [SMP_W-1:0]  in_sample,
  input  logic [RIDX_W-1:0]        in_read_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_result_value,
  output logic [RIDX_W-1:0]        out_result_index,
  output logic                     out_result_ready,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW      = MAX_LENGTH_LOG2;
  localparam int MAX_LEN = 1 << AW;
  localparam int TW      = $clog2(MAX_TAPS);
  localparam int LGW     = $clog2(MAX_LENGTH_LOG2 + 1);
  localparam int SW      = ((AW + 1 > TW) ? AW + 1 : TW) + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_MAC, ST_DRN, ST_SC0, ST_SC1, ST_SC2, ST_CPY
  } state_t;

  // Memories
  logic signed [COEF_W-1:0] tap_mem [MAX_TAPS];
  logic signed [SMP_W-1:0]  smp_mem [MAX_LEN];
  logic signed [WORD_W-1:0] wrk_mem [MAX_LEN];
  logic signed [WORD_W-1:0] res_mem [MAX_LEN];

  logic signed [COEF_W-1:0] tap_lo_rd_r, tap_hi_rd_r;
  logic signed [SMP_W-1:0]  smp_rd_r;
  logic signed [WORD_W-1:0] wrk_rd_r, res_rd_r;

  // Control state
  state_t                  state_r, state_nxt;
  logic [LEN_REG_W-1:0]    len_reg_r, len_reg_nxt;
  logic [LEV_REG_W-1:0]    lev_reg_r, lev_reg_nxt;
  logic [TAPS_REG_W-1:0]   taps_reg_r, taps_reg_nxt;
  logic [AW:0]             cnt_r, cnt_nxt;
  logic                    have_r, have_nxt;
  logic [LGW-1:0]          lev_r, lev_nxt;
  logic [LGW-1:0]          lg_r, lg_nxt;
  logic [AW-1:0]           i_r, i_nxt;
  logic [TW-1:0]           j_r, j_nxt;
  logic [AW-1:0]           cp_cnt_r, cp_cnt_nxt;
  logic                    cp_wr_v_r;
  logic [AW-1:0]           cp_wa_r;
  logic [RIDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                    rd_ok_r, rd_ok_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] out_value_r, out_value_nxt;
  logic [RIDX_W-1:0]       out_index_r, out_index_nxt;
  logic                    out_ready_r, out_ready_nxt;

  // Derived values
  logic [LGW-1:0]          l_eff, d_eff;
  logic [TW:0]             t_eff;
  logic [AW:0]             len_cfg, len_lvl, half_lvl, cnt_inc;
  logic [SW-1:0]           da_sum;
  logic [AW-1:0]           da, res_ra;
  logic [TW-1:0]           hp_ra;
  logic                    in_acc, cfg_acc;

  // Memory write strobes
  logic                    tap_we, smp_we, res_we;
  logic [AW-1:0]           res_wa;
  logic signed [WORD_W-1:0] res_wd;

  mac_ctl_t                ctl;
  logic                    mac_busy;
  logic signed [WORD_W-1:0] mac_res;
  logic signed [WORD_W-1:0] x_in;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_acc   = cfg_valid & cfg_ready;

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_index = out_index_r;
  assign out_result_ready = out_ready_r;

  // Clamp the registers to their usable ranges
  always_comb begin
    if (len_reg_r == '0) begin
      l_eff = LGW'(1);
    end else if (int'(len_reg_r) > MAX_LENGTH_LOG2) begin
      l_eff = LGW'(MAX_LENGTH_LOG2);
    end else begin
      l_eff = LGW'(len_reg_r);
    end
    if (lev_reg_r == '0) begin
      d_eff = LGW'(1);
    end else if (int'(lev_reg_r) > int'(l_eff)) begin
      d_eff = l_eff;
    end else begin
      d_eff = LGW'(lev_reg_r);
    end
    if (taps_reg_r == '0) begin
      t_eff = (TW + 1)'(1);
    end else if (int'(taps_reg_r) > MAX_TAPS) begin
      t_eff = (TW + 1)'(MAX_TAPS);
    end else begin
      t_eff = (TW + 1)'(taps_reg_r);
    end
  end

  // Circular addressing: data at (2i + j) mod level length; mirror tap t-1-j
  always_comb begin
    len_cfg  = (AW + 1)'(1) << l_eff;
    len_lvl  = (AW + 1)'(1) << lg_r;
    half_lvl = len_lvl >> 1;
    cnt_inc  = cnt_r + (AW + 1)'(1);
    da_sum   = SW'({i_r, 1'b0}) + SW'(j_r);
    da       = AW'(da_sum & SW'(len_lvl - (AW + 1)'(1)));
    hp_ra    = TW'(t_eff - (TW + 1)'(1) - (TW + 1)'(j_r));
    if (state_r == ST_CPY) begin
      res_ra = cp_cnt_r;
    end else if (state_r == ST_IDLE) begin
      res_ra = AW'(in_read_index);
    end else begin
      res_ra = AW'(rd_idx_r);
    end
  end

  // The first level reads the sample memory, later ones the work memory
  assign x_in = (lev_r == '0) ? WORD_W'(smp_rd_r) : wrk_rd_r;

  pwa_mac #(
    .MAX_TAPS(MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .tap_lo (tap_lo_rd_r),
    .tap_hi (tap_hi_rd_r),
    .x      (x_in),
    .busy   (mac_busy),
    .result (mac_res)
  );

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    len_reg_nxt   = len_reg_r;
    lev_reg_nxt   = lev_reg_r;
    taps_reg_nxt  = taps_reg_r;
    cnt_nxt       = cnt_r;
    have_nxt      = have_r;
    lev_nxt       = lev_r;
    lg_nxt        = lg_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cp_cnt_nxt    = cp_cnt_r;
    rd_idx_nxt    = rd_idx_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_ready_nxt = out_ready_r;
    tap_we        = 1'b0;
    smp_we        = 1'b0;
    res_we        = 1'b0;
    res_wa        = i_r;
    res_wd        = mac_res;
    ctl           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          unique case (cfg_index)
            REG_LENGTH_LOG2: begin
              len_reg_nxt = cfg_data[LEN_REG_W-1:0];
              cnt_nxt     = '0;
              have_nxt    = 1'b0;
            end
            REG_LEVELS: begin
              lev_reg_nxt = cfg_data[LEV_REG_W-1:0];
              cnt_nxt     = '0;
              have_nxt    = 1'b0;
            end
            REG_TAPS: begin
              taps_reg_nxt = cfg_data[TAPS_REG_W-1:0];
              cnt_nxt      = '0;
              have_nxt     = 1'b0;
            end
            default: begin
            end
          endcase
        end
        if (in_acc) begin
          unique case (in_func)
            FUNC_LOAD: begin
              tap_we = 1'b1;
            end
            FUNC_PUSH: begin
              smp_we = 1'b1;
              if (cnt_inc >= len_cfg) begin
                // Frame complete: start level zero
                cnt_nxt   = '0;
                lev_nxt   = '0;
                lg_nxt    = l_eff;
                i_nxt     = '0;
                j_nxt     = '0;
                ctl.clear = 1'b1;
                state_nxt = ST_MAC;
              end else begin
                cnt_nxt = cnt_inc;
              end
            end
            FUNC_READ: begin
              rd_idx_nxt = in_read_index;
              rd_ok_nxt  = have_r && (32'(in_read_index) < 32'(len_cfg));
              state_nxt  = ST_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_ok_r ? res_rd_r : '0;
          out_index_nxt = rd_idx_r;
          out_ready_nxt = have_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_MAC: begin
        ctl.issue = 1'b1;
        ctl.neg   = j_r[0];
        if ((TW + 1)'(j_r) == t_eff - (TW + 1)'(1)) begin
          j_nxt     = '0;
          state_nxt = ST_DRN;
        end else begin
          j_nxt = j_r + TW'(1);
        end
      end
      ST_DRN: begin
        if (!mac_busy) begin
          state_nxt = ST_SC0;
        end
      end
      ST_SC0: begin
        ctl.scale_go = 1'b1;
        state_nxt    = ST_SC1;
      end
      ST_SC1: begin
        res_we       = 1'b1;
        res_wa       = i_r;
        ctl.scale_go = 1'b1;
        ctl.scale_hi = 1'b1;
        state_nxt    = ST_SC2;
      end
      ST_SC2: begin
        res_we = 1'b1;
        res_wa = AW'(half_lvl + (AW + 1)'(i_r));
        if ((AW + 1)'(i_r) == half_lvl - (AW + 1)'(1)) begin
          if ((LGW + 1)'(lev_r) + (LGW + 1)'(1) < (LGW + 1)'(d_eff)) begin
            cp_cnt_nxt = '0;
            state_nxt  = ST_CPY;
          end else begin
            have_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          i_nxt     = i_r + AW'(1);
          ctl.clear = 1'b1;
          state_nxt = ST_MAC;
        end
      end
      ST_CPY: begin
        // Move the lowpass half into the work memory for the next level
        if ((AW + 1)'(cp_cnt_r) < half_lvl) begin
          cp_cnt_nxt = cp_cnt_r + AW'(1);
        end else if (!cp_wr_v_r) begin
          lev_nxt   = lev_r + LGW'(1);
          lg_nxt    = lg_r - LGW'(1);
          i_nxt     = '0;
          ctl.clear = 1'b1;
          state_nxt = ST_MAC;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_reg_r   <= RST_LENGTH_LOG2;
      lev_reg_r   <= RST_LEVELS;
      taps_reg_r  <= RST_TAPS;
      cnt_r       <= '0;
      have_r      <= 1'b0;
      lev_r       <= '0;
      lg_r        <= '0;
      i_r         <= '0;
      j_r         <= '0;
      cp_cnt_r    <= '0;
      cp_wr_v_r   <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_reg_r   <= len_reg_nxt;
      lev_reg_r   <= lev_reg_nxt;
      taps_reg_r  <= taps_reg_nxt;
      cnt_r       <= cnt_nxt;
      have_r      <= have_nxt;
      lev_r       <= lev_nxt;
      lg_r        <= lg_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cp_cnt_r    <= cp_cnt_nxt;
      cp_wr_v_r   <= (state_r == ST_CPY) && ((AW + 1)'(cp_cnt_r) < half_lvl);
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cp_wa_r     <= cp_cnt_r;
    rd_idx_r    <= rd_idx_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_ready_r <= out_ready_nxt;
  end

  // Tap memory: one write port, lowpass and mirror read ports
  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[TW'(in_coef_index)] <= in_coef_value;
    end
    tap_lo_rd_r <= tap_mem[j_r];
    tap_hi_rd_r <= tap_mem[hp_ra];
  end

  // Sample and work memories share the data address
  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_mem[cnt_r[AW-1:0]] <= in_sample;
    end
    smp_rd_r <= smp_mem[da];
  end

  always_ff @(posedge clk) begin
    if (cp_wr_v_r) begin
      wrk_mem[cp_wa_r] <= res_rd_r;
    end
    wrk_rd_r <= wrk_mem[da];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_wa] <= res_wd;
    end
    res_rd_r <= res_mem[res_ra];
  end

endmodule
